// ----- sv/scl_pkg.sv -----
// scl_pkg: shared types and codes for the sorted candidate list
// opcodes, result status codes, store entry layout, controller/datapath command and status
// no dependencies
`default_nettype none

package scl_pkg;

    // candidate index space is fixed by the 5-bit entry_index field
    localparam int IDX_W      = 5;
    localparam int CAND_SLOTS = 32;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_APPEND = 2'd2;
    localparam logic [1:0] OP_PICK   = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // flag bit positions inside a store entry
    localparam int FLG_MINR = 0;
    localparam int FLG_ACC  = 1;
    localparam int FLG_ARMA = 2;

    typedef struct packed {
        logic [7:0]  rank;
        logic [31:0] dist_key;
        logic [2:0]  flags;
    } scl_entry_t;

    typedef struct packed {
        logic capture;
        logic start_scan;
        logic start_pick;
        logic start_shift;
        logic step;
        logic write_new;
        logic load_out;
    } scl_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic found;
        logic exhausted;
        logic shift_done;
    } scl_stat_t;

endpackage

`default_nettype wire

// ----- sv/scl_ctrl.sv -----
// scl_ctrl: sequencing state machine for the sorted candidate list
// drives scl_dpath through scl_cmd_t and reacts to scl_stat_t
// depends on scl_pkg
`default_nettype none

module scl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    output logic               out_valid,
    input  logic               out_stall,
    input  scl_pkg::scl_stat_t stat,
    output scl_pkg::scl_cmd_t  cmd
);
    import scl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_SHIFT,
        S_WRITE,
        S_PICK,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (opcode)
                        OP_INSERT:
                        begin
                            if (stat.full)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cmd.start_scan = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        OP_APPEND:
                        begin
                            state_next = stat.full ? S_RESP : S_WRITE;
                        end
                        OP_PICK:
                        begin
                            if (stat.empty)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cmd.start_pick = 1'b1;
                                state_next     = S_PICK;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.found || stat.exhausted)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.start_shift = 1'b1;
                state_next      = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.step = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write_new = 1'b1;
                state_next    = S_RESP;
            end
            S_PICK:
            begin
                cmd.step = 1'b1;
                if (stat.found || stat.exhausted)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- sv/scl_dpath.sv -----
// scl_dpath: order list and candidate store memories, walk pipeline, result registers
// runs under commands from scl_ctrl
// depends on scl_pkg
`default_nettype none

module scl_dpath #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  scl_pkg::scl_cmd_t         cmd,
    output scl_pkg::scl_stat_t        stat,
    input  logic                      cfg_wr_en,
    input  logic [7:0]                cfg_wr_data,
    input  logic [1:0]                opcode,
    input  logic [scl_pkg::IDX_W-1:0] entry_index,
    input  logic [7:0]                rank,
    input  logic [31:0]               distance,
    input  logic                      min_range_flag,
    input  logic                      accepted,
    input  logic                      arm_a_target,
    input  logic [7:0]                pick_category,
    input  logic                      node_flag,
    output logic [1:0]                status,
    output logic [5:0]                position,
    output logic [5:0]                list_count,
    output logic [scl_pkg::IDX_W-1:0] picked_index
);
    import scl_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        MODE_SCAN,
        MODE_PICK,
        MODE_SHIFT
    } mode_t;

    // memories
    logic [IDX_W-1:0] ord_mem [MAX_ENTRIES];
    scl_entry_t       st_mem  [CAND_SLOTS];

    // control
    logic [7:0]    tcat_reg;
    logic [CW-1:0] count_reg;
    mode_t         mode_reg;
    logic [CW-1:0] left_reg;
    logic [AW-1:0] ptr_reg;
    logic          v1_reg;
    logic          v2_reg;

    // walk pipeline payload
    logic [AW-1:0]    ptr1_reg;
    logic [AW-1:0]    ptr2_reg;
    logic [IDX_W-1:0] ord_q_reg;
    logic [IDX_W-1:0] idx2_reg;
    scl_entry_t       st_q_reg;

    // latched word and per-operation results
    logic [IDX_W-1:0] it_idx_reg;
    logic [7:0]       it_rank_reg;
    logic [31:0]      it_dist_reg;
    logic [2:0]       it_flags_reg;
    logic [7:0]       it_cat_reg;
    logic             it_node_reg;
    logic [CW-1:0]    at_reg;
    logic [1:0]       status_reg;
    logic [CW-1:0]    pos_reg;
    logic [IDX_W-1:0] picked_reg;

    logic [1:0]       out_status_reg;
    logic [5:0]       out_pos_reg;
    logic [5:0]       out_count_reg;
    logic [IDX_W-1:0] out_picked_reg;

    logic issue;
    logic hit;
    logic keep;
    logic found;
    logic exhausted;
    logic start;

    assign start = cmd.start_scan || cmd.start_pick || cmd.start_shift;
    assign issue = cmd.step && (left_reg != '0);

    // insert stops before an entry of lower rank, or equal rank and smaller distance
    assign hit = (it_rank_reg > st_q_reg.rank) ||
                 ((it_rank_reg == st_q_reg.rank) && (it_dist_reg > st_q_reg.dist_key));

    assign keep = !st_q_reg.flags[FLG_MINR] && st_q_reg.flags[FLG_ACC] &&
                  !((it_cat_reg == tcat_reg) && st_q_reg.flags[FLG_ARMA] && !it_node_reg);

    assign found = v2_reg && (((mode_reg == MODE_SCAN) && hit) ||
                              ((mode_reg == MODE_PICK) && keep));
    assign exhausted = (left_reg == '0) && !v1_reg && !v2_reg;

    assign stat.full       = (count_reg == CW'(MAX_ENTRIES));
    assign stat.empty      = (count_reg == '0);
    assign stat.found      = found;
    assign stat.exhausted  = exhausted;
    assign stat.shift_done = (left_reg == '0) && !v1_reg;

    // walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcat_reg  <= '0;
            count_reg <= '0;
            mode_reg  <= MODE_SCAN;
            left_reg  <= '0;
            ptr_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tcat_reg <= cfg_wr_data;
            end

            if (cmd.capture && (opcode == OP_CLEAR))
            begin
                count_reg <= '0;
            end
            else if (cmd.write_new)
            begin
                count_reg <= CW'(count_reg + 1'b1);
            end

            if (cmd.start_scan)
            begin
                mode_reg <= MODE_SCAN;
                ptr_reg  <= '0;
                left_reg <= count_reg;
            end
            else if (cmd.start_pick)
            begin
                mode_reg <= MODE_PICK;
                ptr_reg  <= AW'(count_reg - 1'b1);
                left_reg <= count_reg;
            end
            else if (cmd.start_shift)
            begin
                mode_reg <= MODE_SHIFT;
                ptr_reg  <= AW'(count_reg - 1'b1);
                left_reg <= CW'(count_reg - at_reg);
            end
            else if (issue)
            begin
                left_reg <= CW'(left_reg - 1'b1);
                if (mode_reg == MODE_SCAN)
                begin
                    ptr_reg <= AW'(ptr_reg + 1'b1);
                end
                else
                begin
                    ptr_reg <= AW'(ptr_reg - 1'b1);
                end
            end

            v1_reg <= !start && issue;
            v2_reg <= !start && cmd.step && v1_reg;
        end
    end

    // pipeline payload and memory reads
    always_ff @(posedge clk)
    begin
        ptr1_reg  <= ptr_reg;
        ptr2_reg  <= ptr1_reg;
        idx2_reg  <= ord_q_reg;
        ord_q_reg <= ord_mem[ptr_reg];
        st_q_reg  <= st_mem[ord_q_reg];
    end

    // order list write: new index, or one slot of the tail shift
    always_ff @(posedge clk)
    begin
        if (cmd.write_new)
        begin
            ord_mem[at_reg[AW-1:0]] <= it_idx_reg;
        end
        else if (cmd.step && (mode_reg == MODE_SHIFT) && v1_reg)
        begin
            ord_mem[AW'(ptr1_reg + 1'b1)] <= ord_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_new)
        begin
            st_mem[it_idx_reg] <= '{rank: it_rank_reg, dist_key: it_dist_reg,
                                    flags: it_flags_reg};
        end
    end

    // latched word and results
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            it_idx_reg   <= entry_index;
            it_rank_reg  <= rank;
            it_dist_reg  <= distance;
            it_flags_reg <= {arm_a_target, accepted, min_range_flag};
            it_cat_reg   <= pick_category;
            it_node_reg  <= node_flag;
            at_reg       <= count_reg;
            pos_reg      <= '0;
            picked_reg   <= '0;
            if (((opcode == OP_INSERT) || (opcode == OP_APPEND)) && stat.full)
            begin
                status_reg <= ST_FULL;
            end
            else if (opcode == OP_PICK)
            begin
                status_reg <= ST_NONE;
            end
            else
            begin
                status_reg <= ST_DONE;
            end
        end
        else
        begin
            if (cmd.step && (mode_reg == MODE_SCAN) && (found || exhausted))
            begin
                at_reg <= found ? CW'(ptr2_reg) : count_reg;
            end
            if (cmd.step && (mode_reg == MODE_PICK) && found)
            begin
                picked_reg <= idx2_reg;
                status_reg <= ST_DONE;
            end
            if (cmd.write_new)
            begin
                pos_reg <= at_reg;
            end
        end

        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_pos_reg    <= 6'(pos_reg);
            out_count_reg  <= 6'(count_reg);
            out_picked_reg <= picked_reg;
        end
    end

    assign status       = out_status_reg;
    assign position     = out_pos_reg;
    assign list_count   = out_count_reg;
    assign picked_index = out_picked_reg;

endmodule

`default_nettype wire

// ----- sv/sorted_candidate_list_pick.sv -----
// throughput: one word at a time, the input opens again as out_valid rises (later
// while an earlier result is still stalled); walks step one entry per cycle behind
// a two-deep registered read (order list, then candidate store)
// reset: asynchronous active low, empties the list and clears torpedo_category
`default_nettype none

module sorted_candidate_list_pick #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [7:0]                cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                opcode,
    input  logic [scl_pkg::IDX_W-1:0] entry_index,
    input  logic [7:0]                rank,
    input  logic [31:0]               distance,
    input  logic                      min_range_flag,
    input  logic                      accepted,
    input  logic                      arm_a_target,
    input  logic [7:0]                pick_category,
    input  logic                      node_flag,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic [5:0]                position,
    output logic [5:0]                list_count,
    output logic [scl_pkg::IDX_W-1:0] picked_index
);
    import scl_pkg::*;

    scl_cmd_t  cmd;
    scl_stat_t stat;

    scl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    scl_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .opcode         (opcode),
        .entry_index    (entry_index),
        .rank           (rank),
        .distance       (distance),
        .min_range_flag (min_range_flag),
        .accepted       (accepted),
        .arm_a_target   (arm_a_target),
        .pick_category  (pick_category),
        .node_flag      (node_flag),
        .status         (status),
        .position       (position),
        .list_count     (list_count),
        .picked_index   (picked_index)
    );

`ifndef NO_ASSERTIONS
    // one word in flight: input side closes right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a word is still in progress");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (list_count == 6'(MAX_ENTRIES)))
        else $error("full status with list not at capacity");

    a_none_picked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_NONE)) |-> (picked_index == '0))
        else $error("pick with no target returned a nonzero index");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_DONE)) |-> (position == '0))
        else $error("nonzero position on a failed operation");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench for sorted_candidate_list_pick: directed and random words checked against
// a behavioral list model kept here; depends on scl_pkg and the block's RTL only

module testbench;

    import scl_pkg::*;

    localparam int LIST_DEPTH  = 32;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 160;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  idx;
        logic [7:0]  rank;
        logic [31:0] dist_key;
        logic        minr;
        logic        acc;
        logic        arma;
        logic [7:0]  cat;
        logic        node;
    } cand_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] position;
        logic [5:0] count;
        logic [4:0] picked;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = OP_CLEAR;
    logic [4:0]  entry_index = 5'd0;
    logic [7:0]  rank = 8'd0;
    logic [31:0] distance = 32'd0;
    logic        min_range_flag = 1'b0;
    logic        accepted = 1'b0;
    logic        arm_a_target = 1'b0;
    logic [7:0]  pick_category = 8'd0;
    logic        node_flag = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [5:0]  position;
    logic [5:0]  list_count;
    logic [4:0]  picked_index;

    // list model
    logic [4:0]  order_m [LIST_DEPTH];
    int          list_len = 0;
    logic [7:0]  rank_m [CAND_SLOTS];
    logic [31:0] dist_m [CAND_SLOTS];
    logic [2:0]  flag_m [CAND_SLOTS];
    logic [7:0]  torp_m = 8'd0;

    cand_word_t   pending_words[$];
    list_result_t expected_results[$];
    cand_word_t   drive_word;
    list_result_t new_result;
    list_result_t want;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int words_sent = 0;
    int full_rejects = 0;
    int picks_hit = 0;
    int picks_none = 0;

    sorted_candidate_list_pick #(
        .MAX_ENTRIES(LIST_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .entry_index(entry_index),
        .rank(rank),
        .distance(distance),
        .min_range_flag(min_range_flag),
        .accepted(accepted),
        .arm_a_target(arm_a_target),
        .pick_category(pick_category),
        .node_flag(node_flag),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .position(position),
        .list_count(list_count),
        .picked_index(picked_index)
    );

    function automatic list_result_t apply_word(input cand_word_t w);
        list_result_t r;
        int slot;
        int k;
        logic [4:0] c;
        logic [2:0] f;
        r = '0;
        case (w.op)
            OP_CLEAR: list_len = 0;
            OP_INSERT, OP_APPEND:
            begin
                if (list_len >= LIST_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    slot = list_len;
                    if (w.op == OP_INSERT)
                    begin
                        // walking up from the tail leaves the first hit from the head
                        for (k = list_len - 1; k >= 0; k--)
                        begin
                            c = order_m[k];
                            if (w.rank > rank_m[c] ||
                                (w.rank == rank_m[c] && w.dist_key > dist_m[c]))
                                slot = k;
                        end
                    end
                    for (k = list_len; k > slot; k--)
                        order_m[k] = order_m[k - 1];
                    order_m[slot] = w.idx;
                    list_len++;
                    rank_m[w.idx] = w.rank;
                    dist_m[w.idx] = w.dist_key;
                    f[FLG_MINR] = w.minr;
                    f[FLG_ACC] = w.acc;
                    f[FLG_ARMA] = w.arma;
                    flag_m[w.idx] = f;
                    r.position = slot[5:0];
                end
            end
            default:
            begin
                r.status = ST_NONE;
                for (k = list_len - 1; k >= 0 && r.status == ST_NONE; k--)
                begin
                    c = order_m[k];
                    f = flag_m[c];
                    if (!f[FLG_MINR] && f[FLG_ACC] &&
                        !(w.cat == torp_m && f[FLG_ARMA] && !w.node))
                    begin
                        r.status = ST_DONE;
                        r.picked = c;
                    end
                end
            end
        endcase
        r.count = list_len[5:0];
        return r;
    endfunction

    function automatic cand_word_t make_word(input logic [1:0] op, input logic [4:0] idx,
                                             input logic [7:0] rk, input logic [31:0] dk,
                                             input logic minr, input logic acc,
                                             input logic arma, input logic [7:0] cat,
                                             input logic node);
        cand_word_t w;
        w.op = op;
        w.idx = idx;
        w.rank = rk;
        w.dist_key = dk;
        w.minr = minr;
        w.acc = acc;
        w.arma = arma;
        w.cat = cat;
        w.node = node;
        return w;
    endfunction

    function automatic cand_word_t rand_word(input logic [1:0] op, input logic [7:0] torp);
        cand_word_t w;
        int pick;
        w.op = op;
        w.idx = 5'($urandom_range(31));
        // narrow ranks and distances make ties common
        pick = $urandom_range(3);
        if (pick == 0)
            w.rank = 8'($urandom_range(3));
        else if (pick == 1)
            w.rank = $urandom_range(1) ? 8'hFF : 8'h00;
        else
            w.rank = 8'($urandom_range(255));
        w.dist_key = $urandom_range(1) ? 32'($urandom_range(3)) : 32'($urandom);
        w.minr = ($urandom_range(3) == 0);
        w.acc = ($urandom_range(3) != 0);
        w.arma = 1'($urandom_range(1));
        w.cat = $urandom_range(1) ? torp : 8'($urandom_range(255));
        w.node = 1'($urandom_range(1));
        return w;
    endfunction

    task automatic fill_random(input int target, input logic [7:0] torp);
        int made;
        int run_len;
        int roll;
        int k;
        bit heavy;
        logic [1:0] op;
        made = 0;
        while (made < target)
        begin
            heavy = ($urandom_range(3) == 0);
            run_len = heavy ? $urandom_range(45, 34) : $urandom_range(20, 3);
            // most runs start from an empty list, the rest build on what is left
            if ($urandom_range(9) != 0)
            begin
                pending_words.push_back(rand_word(OP_CLEAR, torp));
                made++;
            end
            for (k = 0; k < run_len; k++)
            begin
                roll = $urandom_range(99);
                if (heavy)
                    op = roll < 70 ? OP_INSERT : (roll < 95 ? OP_APPEND : OP_PICK);
                else
                    op = roll < 40 ? OP_INSERT : (roll < 60 ? OP_APPEND :
                         (roll < 95 ? OP_PICK : OP_CLEAR));
                pending_words.push_back(rand_word(op, torp));
                made++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            fail_count++;
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                new_result = apply_word(drive_word);
                expected_results.push_back(new_result);
                words_sent++;
                if (new_result.status == ST_FULL)
                    full_rejects++;
                if (drive_word.op == OP_PICK)
                begin
                    if (new_result.status == ST_NONE)
                        picks_none++;
                    else
                        picks_hit++;
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drive_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    opcode <= drive_word.op;
                    entry_index <= drive_word.idx;
                    rank <= drive_word.rank;
                    distance <= drive_word.dist_key;
                    min_range_flag <= drive_word.minr;
                    accepted <= drive_word.acc;
                    arm_a_target <= drive_word.arma;
                    pick_category <= drive_word.cat;
                    node_flag <= drive_word.node;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %0d %0d %0d %0d",
                             $time, status, position, list_count, picked_index);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("position", 32'(want.position), 32'(position));
                    check_field("list_count", 32'(want.count), 32'(list_count));
                    check_field("picked_index", 32'(want.picked), 32'(picked_index));
                end
            end
        end
    end

    initial
    begin
        logic [7:0] cfg_plan [PHASES];
        int ph;
        cfg_plan[0] = 8'h00;
        cfg_plan[1] = 8'hFF;
        cfg_plan[2] = 8'($urandom_range(255));
        cfg_plan[3] = 8'h80;
        cfg_plan[4] = 8'h01;
        cfg_plan[5] = 8'($urandom_range(255));
        cfg_plan[6] = 8'hFF;
        cfg_plan[7] = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            repeat (6) @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= cfg_plan[ph];
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            torp_m = cfg_plan[ph];
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 59;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 59;
                end
                default:
                begin
                    send_idle_pct = 19;
                    stall_pct = 19;
                end
            endcase
            if (ph == 0)
            begin
                // empty pick right after reset, tie breaks, extremes, duplicate index,
                // each skip reason, then clear and a pick on the emptied list
                pending_words.push_back(make_word(OP_PICK, 0, 0, 0, 0, 1, 0, 8'hFF, 1));
                pending_words.push_back(make_word(OP_INSERT, 3, 10, 100, 0, 1, 0, 0, 0));
                pending_words.push_back(make_word(OP_INSERT, 5, 10, 200, 0, 1, 0, 0, 0));
                pending_words.push_back(make_word(OP_INSERT, 7, 10, 100, 0, 1, 1, 0, 0));
                pending_words.push_back(make_word(OP_INSERT, 0, 8'hFF, 0, 0, 1, 0, 0, 0));
                pending_words.push_back(make_word(OP_INSERT, 31, 0, 32'hFFFF_FFFF, 0, 0, 0,
                                                  0, 0));
                pending_words.push_back(make_word(OP_APPEND, 9, 200, 5, 1, 1, 0, 0, 0));
                pending_words.push_back(make_word(OP_INSERT, 3, 50, 7, 0, 1, 1, 0, 0));
                pending_words.push_back(make_word(OP_PICK, 0, 0, 0, 0, 0, 0, 0, 0));
                pending_words.push_back(make_word(OP_PICK, 0, 0, 0, 0, 0, 0, 0, 1));
                pending_words.push_back(make_word(OP_PICK, 0, 0, 0, 0, 0, 0, 8'hFF, 0));
                pending_words.push_back(make_word(OP_APPEND, 12, 0, 0, 1, 1, 1, 0, 0));
                pending_words.push_back(make_word(OP_INSERT, 30, 8'hFF, 32'hFFFF_FFFF, 0,
                                                  1, 1, 8'hFF, 1));
                pending_words.push_back(make_word(OP_PICK, 0, 0, 0, 0, 0, 0, 0, 0));
                pending_words.push_back(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
                pending_words.push_back(make_word(OP_PICK, 0, 0, 0, 0, 1, 0, 0, 1));
                pending_words.push_back(make_word(OP_APPEND, 1, 1, 1, 0, 1, 1, 0, 0));
                pending_words.push_back(make_word(OP_PICK, 0, 0, 0, 0, 0, 0, 0, 0));
            end
            fill_random(PHASE_WORDS, cfg_plan[ph]);
        end
        wait_drained();
        repeat (80) @(posedge clk);
        $display("ran %0d words over %0d register settings and idle patterns", words_sent,
                 PHASES);
        $display("picks with a target %0d, without %0d, full-list rejects %0d", picks_hit,
                 picks_none, full_rejects);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
